[hw/rtl/sabm_pkg.sv]
// ----------------------------------------------------------------------------
// sabm_pkg
// Shared types and constants for the shift-add / Booth multiplier pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package sabm_pkg;

    // Default operand width in bits.
    localparam int unsigned WIDTH_DEFAULT = 16;

    // Operation selector carried with every transaction.
    typedef enum logic
    {
        FUNC_UNSIGNED = 1'b0,
        FUNC_SIGNED   = 1'b1
    } func_t;

    // Booth recoding of the pair {current multiplier bit, previous bit}.
    typedef enum logic [1:0]
    {
        BOOTH_HOLD_LO = 2'b00,
        BOOTH_ADD     = 2'b01,
        BOOTH_SUB     = 2'b10,
        BOOTH_HOLD_HI = 2'b11
    } booth_pair_t;

endpackage : sabm_pkg

`default_nettype wire

[hw/rtl/sabm_operand_prep.sv]
// ----------------------------------------------------------------------------
// sabm_operand_prep
// Entry stage: extends both operands by one bit according to the mode.
// ----------------------------------------------------------------------------
`default_nettype none

module sabm_operand_prep #(
    parameter int unsigned WIDTH = sabm_pkg::WIDTH_DEFAULT
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               accept,
    input  wire logic               func,
    input  wire logic [WIDTH-1:0]   multiplicand,
    input  wire logic [WIDTH-1:0]   multiplier,
    output logic                    valid_reg,
    output logic [WIDTH:0]          mcand_reg,
    output logic [WIDTH:0]          mplier_reg
);

    logic           sign_mode;
    logic [WIDTH:0] mcand_next;
    logic [WIDTH:0] mplier_next;

    // In signed mode the extra bit copies the sign, otherwise it is zero, so
    // a single signed Booth datapath covers both modes exactly.
    always_comb
    begin
        sign_mode   = (sabm_pkg::func_t'(func) == sabm_pkg::FUNC_SIGNED);
        mcand_next  = {sign_mode & multiplicand[WIDTH-1], multiplicand};
        mplier_next = {sign_mode & multiplier[WIDTH-1], multiplier};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
    end

endmodule : sabm_operand_prep

`default_nettype wire

[hw/rtl/sabm_booth_stage.sv]
// ----------------------------------------------------------------------------
// sabm_booth_stage
// One radix-2 Booth step: add, subtract or hold, then arithmetic shift right.
// ----------------------------------------------------------------------------
`default_nettype none

module sabm_booth_stage #(
    parameter int unsigned WIDTH = sabm_pkg::WIDTH_DEFAULT
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    input  wire logic [WIDTH+1:0]   in_acc,
    input  wire logic [WIDTH:0]     in_q,
    input  wire logic               in_qm1,
    input  wire logic [WIDTH:0]     in_mcand,
    output logic                    valid_reg,
    output logic [WIDTH+1:0]        acc_reg,
    output logic [WIDTH:0]          q_reg,
    output logic                    qm1_reg,
    output logic [WIDTH:0]          mcand_reg
);

    logic [WIDTH+1:0] mcand_wide;
    logic [WIDTH+1:0] acc_sum;
    logic [WIDTH+1:0] acc_next;
    logic [WIDTH:0]   q_next;
    logic             qm1_next;

    always_comb
    begin
        mcand_wide = {in_mcand[WIDTH], in_mcand};
        case (sabm_pkg::booth_pair_t'({in_q[0], in_qm1}))
            sabm_pkg::BOOTH_ADD: acc_sum = in_acc + mcand_wide;
            sabm_pkg::BOOTH_SUB: acc_sum = in_acc - mcand_wide;
            default:             acc_sum = in_acc;
        endcase
        // Arithmetic shift of the concatenation {acc, q, q-1}.
        acc_next = {acc_sum[WIDTH+1], acc_sum[WIDTH+1:1]};
        q_next   = {acc_sum[0], in_q[WIDTH:1]};
        qm1_next = in_q[0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg   <= acc_next;
        q_reg     <= q_next;
        qm1_reg   <= qm1_next;
        mcand_reg <= in_mcand;
    end

endmodule : sabm_booth_stage

`default_nettype wire

[hw/rtl/shift_add_and_booth_multiplier.sv]
// ----------------------------------------------------------------------------
// shift_add_and_booth_multiplier
// Pipelined multiplier: unsigned shift-add (func 0) or signed radix-2 Booth
// (func 1), one operand pair per clock, 2*WIDTH-bit product.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake            Payload                           Dir
//  -------   ------------------   -------------------------------   ---
//  command   start / busy         func, multiplicand, multiplier    in
//  result    done (one cycle)     product                           out
//
// A transaction is taken at every rising edge with start high and busy low.
// Busy is never raised: a new transaction may be issued in every cycle.
// The pipeline has one operand-extension stage followed by WIDTH+1
// Booth step stages, each holding one add/subtract of WIDTH+2 bits.
// The result is shown for exactly one cycle with done high; the receiver
// cannot hold it off, and the pipeline never stalls.
// Reset clears only the valid bits, so no spurious done follows reset.
//
// Both modes share one signed datapath. The operands are widened to WIDTH+1
// bits, by zero extension in unsigned mode and by sign extension in Booth
// mode, and WIDTH+1 radix-2 Booth steps then give the exact product. In
// unsigned mode this equals what the classic carry/accumulator/multiplier
// shift-and-add sequence leaves. The accumulator is WIDTH+2 bits wide so
// that no step overflows, even for the most negative multiplicand.
// ----------------------------------------------------------------------------
`default_nettype none

module shift_add_and_booth_multiplier #(
    parameter int unsigned WIDTH = sabm_pkg::WIDTH_DEFAULT
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire logic                 func,
    input  wire logic [WIDTH-1:0]     multiplicand,
    input  wire logic [WIDTH-1:0]     multiplier,
    output logic                      done,
    output logic [2*WIDTH-1:0]        product
);

    // Number of Booth steps, one per pipeline stage.
    localparam int unsigned NSTEP = WIDTH + 1;

    logic             accept;

    // Stage interconnect; index 0 is the output of the extension stage.
    logic             valid_s [0:NSTEP];
    logic [WIDTH+1:0] acc_s   [0:NSTEP];
    logic [WIDTH:0]   q_s     [0:NSTEP];
    logic             qm1_s   [0:NSTEP];
    logic [WIDTH:0]   mcand_s [0:NSTEP];

    // The pipeline advances unconditionally, so it can always take a new
    // transaction.
    assign busy   = 1'b0;
    assign accept = start & ~busy;

    sabm_operand_prep #(
        .WIDTH (WIDTH)
    ) u_prep (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .func         (func),
        .multiplicand (multiplicand),
        .multiplier   (multiplier),
        .valid_reg    (valid_s[0]),
        .mcand_reg    (mcand_s[0]),
        .mplier_reg   (q_s[0])
    );

    // The accumulator and the previous-bit flag start at zero for each
    // transaction.
    assign acc_s[0] = '0;
    assign qm1_s[0] = 1'b0;

    for (genvar gi = 0; gi < NSTEP; gi++)
    begin : g_step
        sabm_booth_stage #(
            .WIDTH (WIDTH)
        ) u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (valid_s[gi]),
            .in_acc    (acc_s[gi]),
            .in_q      (q_s[gi]),
            .in_qm1    (qm1_s[gi]),
            .in_mcand  (mcand_s[gi]),
            .valid_reg (valid_s[gi+1]),
            .acc_reg   (acc_s[gi+1]),
            .q_reg     (q_s[gi+1]),
            .qm1_reg   (qm1_s[gi+1]),
            .mcand_reg (mcand_s[gi+1])
        );
    end

    // After the last step {acc, q} holds the exact product; its low 2*WIDTH
    // bits are the result. The final multiplicand copy and previous-bit
    // flag are not needed here.
    assign done    = valid_s[NSTEP];
    assign product = {acc_s[NSTEP][WIDTH-2:0], q_s[NSTEP]};

endmodule : shift_add_and_booth_multiplier

`default_nettype wire

[hw/rtl/sabm_checker.sv]
// ----------------------------------------------------------------------------
// sabm_checker
// Port-level checks on result timing and product values, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module sabm_checker #(
    parameter int unsigned WIDTH = sabm_pkg::WIDTH_DEFAULT
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  wire logic                 busy,
    input  wire logic                 func,
    input  wire logic [WIDTH-1:0]     multiplicand,
    input  wire logic [WIDTH-1:0]     multiplier,
    input  wire logic                 done,
    input  wire logic [2*WIDTH-1:0]   product
);

    localparam int unsigned LATENCY = WIDTH + 2;
    localparam int unsigned HIST_W  = $clog2(LATENCY + 1);

    logic                      taken;
    logic [2*WIDTH-1:0]        uprod;
    logic signed [2*WIDTH-1:0] sprod;
    logic [HIST_W-1:0]         hist_reg;
    logic [HIST_W-1:0]         hist_next;
    logic                      hist_full;

    assign taken = start & ~busy & rst_n;
    assign uprod = {{WIDTH{1'b0}}, multiplicand} * {{WIDTH{1'b0}}, multiplier};
    assign sprod = $signed({{WIDTH{multiplicand[WIDTH-1]}}, multiplicand})
                 * $signed({{WIDTH{multiplier[WIDTH-1]}}, multiplier});

    // Counts edges since reset up to the latency, so that the timing check
    // never looks back to a point before reset was released.
    assign hist_full = (hist_reg == HIST_W'(LATENCY));
    assign hist_next = hist_full ? hist_reg : hist_reg + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hist_reg <= '0;
        end
        else
        begin
            hist_reg <= hist_next;
        end
    end

    // The pipeline never refuses a transaction.
    a_never_busy : assert property (@(posedge clk) disable iff (!rst_n)
        !busy)
        else $error("busy raised");

    // Exactly one result per transaction, a fixed latency later.
    a_done_timing : assert property (@(posedge clk) disable iff (!rst_n)
        hist_full |-> (done == $past(taken, LATENCY)))
        else $error("result strobe out of step with accepted transactions");

    a_unsigned_product : assert property (@(posedge clk) disable iff (!rst_n)
        (done && ($past(func, LATENCY) == 1'b0)) |->
            (product == $past(uprod, LATENCY)))
        else $error("wrong unsigned product");

    a_signed_product : assert property (@(posedge clk) disable iff (!rst_n)
        (done && ($past(func, LATENCY) == 1'b1)) |->
            (product == $past(sprod, LATENCY)))
        else $error("wrong signed product");

endmodule : sabm_checker

bind shift_add_and_booth_multiplier sabm_checker #(
    .WIDTH (WIDTH)
) u_sabm_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .func         (func),
    .multiplicand (multiplicand),
    .multiplier   (multiplier),
    .done         (done),
    .product      (product)
);

`default_nettype wire
